// File: rtl/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types and constants for the block frame receiver: frame phases,
// result kinds, register indexes and CRC-16 constants.
// ----------------------------------------------------------------------------
package bfr_pkg;

  // Largest payload the receiver will ever take, whatever max_payload says
  localparam int unsigned MAX_BLOCK = 4096;
  localparam logic [15:0] MAX_BLOCK_LEN = 16'(MAX_BLOCK);

  // CRC-16, Modbus form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Frame phases, one-hot
  typedef enum logic [8:0] {
    PH_HUNT1 = 9'b000000001,
    PH_HUNT2 = 9'b000000010,
    PH_SEQHI = 9'b000000100,
    PH_SEQLO = 9'b000001000,
    PH_LENHI = 9'b000010000,
    PH_LENLO = 9'b000100000,
    PH_DATA  = 9'b001000000,
    PH_CRCHI = 9'b010000000,
    PH_CRCLO = 9'b100000000
  } phase_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2,
    KIND_END  = 2'd3
  } kind_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_HEADER_FIRST  = 3'd0,
    REG_HEADER_SECOND = 3'd1,
    REG_ACK_CODE      = 3'd2,
    REG_NAK_CODE      = 3'd3,
    REG_END_SEQUENCE  = 3'd4,
    REG_MAX_PAYLOAD   = 3'd5
  } reg_index_t;

endpackage

// File: rtl/bfr_crc16.sv
// ----------------------------------------------------------------------------
// bfr_crc16
// Byte-wide CRC-16 update, reflected polynomial, eight bit steps unrolled.
// ----------------------------------------------------------------------------
module bfr_crc16 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  // Fold the byte in, then shift out eight bits
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ bfr_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// File: rtl/block_frame_receiver.sv
// ----------------------------------------------------------------------------
// block_frame_receiver
// Byte-serial stop-and-wait frame receiver: header hunt, sequence, length,
// payload pass-through and CRC-16 check, ending each frame with a verdict.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake         | beat carries
//  ---------+-----------+-------------------+----------------------------------
//  in_      | input     | in_valid/in_ready | in_rx_byte
//  out_     | output    | out_valid/out_ready | out_kind, out_byte,
//           |           |                   | out_frame_number
//  cfg_     | input     | cfg_we            | cfg_index, cfg_data
//
//  One byte per cycle sustained while the output is not stalled. A byte waits
//  in the input register, where the byte-wide CRC update and the phase logic
//  act on it, and its result (if any) is registered into the output register when the byte is taken.
//  A stalled output holds the result and the byte behind it; the input side
//  keeps taking beats until the input register is also full.
//  Reset (synchronous, active low) restores the control and configuration registers, clears the
//  sequence and returns to hunting for the first header byte.
//
module block_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [15:0] out_frame_number,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [7:0]  header_first_r, header_second_r, ack_code_r, nak_code_r;
  logic [15:0] end_sequence_r;
  logic [12:0] max_payload_r;

  // Frame state
  bfr_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] expected_seq_r, expected_seq_nxt;
  logic [15:0] current_seq_r, current_seq_nxt;
  logic [15:0] payload_len_r, payload_len_nxt;
  logic [12:0] bytes_seen_r, bytes_seen_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_high_r, crc_high_nxt;

  // Input and output stages
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_byte_r;
  logic [15:0] out_frame_r;

  logic        advance, fire;
  logic [15:0] crc_upd;
  logic [15:0] limit;
  logic [15:0] len_full;
  logic [12:0] bytes_inc;
  logic [15:0] rx_crc;
  logic        res_valid;
  bfr_pkg::kind_t res_kind;
  logic [7:0]  res_byte;

  // Handshake: the output register frees up when empty or taken
  assign advance  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_byte         = out_byte_r;
  assign out_frame_number = out_frame_r;

  bfr_crc16 u_crc (
    .crc_in  (crc_r),
    .data_in (in_byte_r),
    .crc_out (crc_upd)
  );

  // Effective length limit and helper values
  assign limit     = ({3'b000, max_payload_r} > bfr_pkg::MAX_BLOCK_LEN) ?
                     bfr_pkg::MAX_BLOCK_LEN : {3'b000, max_payload_r};
  assign len_full  = {payload_len_r[15:8], in_byte_r};
  assign bytes_inc = bytes_seen_r + 13'd1;
  assign rx_crc    = {crc_high_r, in_byte_r};

  // Phase logic on the byte in the input register
  always_comb begin
    phase_nxt        = phase_r;
    expected_seq_nxt = expected_seq_r;
    current_seq_nxt  = current_seq_r;
    payload_len_nxt  = payload_len_r;
    bytes_seen_nxt   = bytes_seen_r;
    crc_nxt          = crc_r;
    crc_high_nxt     = crc_high_r;
    res_valid        = 1'b0;
    res_kind         = bfr_pkg::KIND_DATA;
    res_byte         = in_byte_r;
    if (fire) begin
      unique case (phase_r)
        bfr_pkg::PH_HUNT1: begin
          if (in_byte_r == header_first_r) begin
            phase_nxt = bfr_pkg::PH_HUNT2;
          end
        end
        bfr_pkg::PH_HUNT2: begin
          if (in_byte_r == header_second_r) begin
            phase_nxt = bfr_pkg::PH_SEQHI;
            crc_nxt   = bfr_pkg::CRC_INIT;
          end else begin
            phase_nxt = bfr_pkg::PH_HUNT1;
          end
        end
        bfr_pkg::PH_SEQHI: begin
          current_seq_nxt = {in_byte_r, 8'h00};
          crc_nxt         = crc_upd;
          phase_nxt       = bfr_pkg::PH_SEQLO;
        end
        bfr_pkg::PH_SEQLO: begin
          current_seq_nxt = {current_seq_r[15:8], in_byte_r};
          crc_nxt         = crc_upd;
          phase_nxt       = bfr_pkg::PH_LENHI;
        end
        bfr_pkg::PH_LENHI: begin
          payload_len_nxt = {in_byte_r, 8'h00};
          crc_nxt         = crc_upd;
          phase_nxt       = bfr_pkg::PH_LENLO;
        end
        bfr_pkg::PH_LENLO: begin
          payload_len_nxt = len_full;
          crc_nxt         = crc_upd;
          bytes_seen_nxt  = '0;
          if (len_full > limit) begin
            // Oversize frame: reject now and hunt again
            phase_nxt = bfr_pkg::PH_HUNT1;
            res_valid = 1'b1;
            res_kind  = bfr_pkg::KIND_NAK;
            res_byte  = nak_code_r;
          end else if (len_full == 16'd0) begin
            phase_nxt = bfr_pkg::PH_CRCHI;
          end else begin
            phase_nxt = bfr_pkg::PH_DATA;
          end
        end
        bfr_pkg::PH_DATA: begin
          crc_nxt        = crc_upd;
          bytes_seen_nxt = bytes_inc;
          if ({3'b000, bytes_inc} >= payload_len_r) begin
            phase_nxt = bfr_pkg::PH_CRCHI;
          end
          res_valid = 1'b1;
        end
        bfr_pkg::PH_CRCHI: begin
          crc_high_nxt = in_byte_r;
          phase_nxt    = bfr_pkg::PH_CRCLO;
        end
        bfr_pkg::PH_CRCLO: begin
          phase_nxt = bfr_pkg::PH_HUNT1;
          res_valid = 1'b1;
          priority if (rx_crc != crc_r) begin
            res_kind = bfr_pkg::KIND_NAK;
            res_byte = nak_code_r;
          end else if (current_seq_r == end_sequence_r && payload_len_r == 16'd0) begin
            expected_seq_nxt = '0;
            res_kind         = bfr_pkg::KIND_END;
            res_byte         = 8'h00;
          end else if (current_seq_r != expected_seq_r) begin
            res_kind = bfr_pkg::KIND_NAK;
            res_byte = nak_code_r;
          end else begin
            expected_seq_nxt = expected_seq_r + 16'd1;
            res_kind         = bfr_pkg::KIND_ACK;
            res_byte         = ack_code_r;
          end
        end
        default: begin
          phase_nxt = bfr_pkg::PH_HUNT1;
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= bfr_pkg::PH_HUNT1;
      expected_seq_r <= '0;
      current_seq_r  <= '0;
      payload_len_r  <= '0;
      bytes_seen_r   <= '0;
      crc_r          <= bfr_pkg::CRC_INIT;
      crc_high_r     <= '0;
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      expected_seq_r <= expected_seq_nxt;
      current_seq_r  <= current_seq_nxt;
      payload_len_r  <= payload_len_nxt;
      bytes_seen_r   <= bytes_seen_nxt;
      crc_r          <= crc_nxt;
      crc_high_r     <= crc_high_nxt;
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= fire && res_valid;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (fire && res_valid) begin
      out_kind_r  <= res_kind;
      out_byte_r  <= res_byte;
      out_frame_r <= current_seq_r;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_first_r  <= 8'hAA;
      header_second_r <= 8'h55;
      ack_code_r      <= 8'h06;
      nak_code_r      <= 8'h15;
      end_sequence_r  <= 16'hFFFF;
      max_payload_r   <= 13'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfr_pkg::REG_HEADER_FIRST:  header_first_r  <= cfg_data[7:0];
        bfr_pkg::REG_HEADER_SECOND: header_second_r <= cfg_data[7:0];
        bfr_pkg::REG_ACK_CODE:      ack_code_r      <= cfg_data[7:0];
        bfr_pkg::REG_NAK_CODE:      nak_code_r      <= cfg_data[7:0];
        bfr_pkg::REG_END_SEQUENCE:  end_sequence_r  <= cfg_data;
        bfr_pkg::REG_MAX_PAYLOAD:   max_payload_r   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/bfr_checker.sv
// ----------------------------------------------------------------------------
// bfr_checker
// Port-level checks on the block frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module bfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_byte,
  input logic [15:0] out_frame_number
);

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds its beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_byte) && $stable(out_frame_number))
    else $error("stalled result changed");

  // Transfer end carries a zero byte
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == bfr_pkg::KIND_END |-> out_byte == 8'h00)
    else $error("transfer end with nonzero byte");

  // An empty result side never blocks the input
  a_in_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with result side empty");

endmodule

bind block_frame_receiver bfr_checker u_bfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_byte         (out_byte),
  .out_frame_number (out_frame_number)
);

// File: tb/bfr_frame_checker.sv
// ----------------------------------------------------------------------------
// bfr_frame_checker
// Watches the byte, result and register ports of the block frame receiver.
// Keeps its own copy of the frame state and registers, works out the result
// each accepted byte should give, and compares result beats in order.
// ----------------------------------------------------------------------------
module bfr_frame_checker
  import bfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_kind,
  input  logic [7:0]  out_byte,
  input  logic [15:0] out_frame_number,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output logic [15:0] next_seq
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  code;
    logic [15:0] frame;
  } frame_result_t;

  // Register copies
  logic [7:0]  hdr_a, hdr_b, ack_val, nak_val;
  logic [15:0] end_seq;
  logic [12:0] max_len;

  // Frame state
  phase_t      rx_phase;
  logic [15:0] rx_seq, rx_len, running_crc;
  logic [7:0]  crc_hi;
  int          data_count;

  frame_result_t frame_results_q[$];

  // Fold one byte into a reflected CRC-16
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int k;
    c = crc ^ {8'h00, b};
    for (k = 0; k < 8; k++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void expect_result(input kind_t kind, input logic [7:0] code,
                                        input logic [15:0] frame);
    frame_result_t r;
    r.kind  = kind;
    r.code  = code;
    r.frame = frame;
    frame_results_q.push_back(r);
  endfunction

  // Advance the frame state by one received byte
  task automatic take_rx_byte(input logic [7:0] b);
    int cap;
    case (rx_phase)
      PH_HUNT1: if (b == hdr_a) rx_phase = PH_HUNT2;
      PH_HUNT2: begin
        if (b == hdr_b) begin
          rx_phase    = PH_SEQHI;
          running_crc = CRC_INIT;
        end else begin
          rx_phase = PH_HUNT1;
        end
      end
      PH_SEQHI: begin
        rx_seq      = {b, 8'h00};
        running_crc = crc_fold(running_crc, b);
        rx_phase    = PH_SEQLO;
      end
      PH_SEQLO: begin
        rx_seq[7:0] = b;
        running_crc = crc_fold(running_crc, b);
        rx_phase    = PH_LENHI;
      end
      PH_LENHI: begin
        rx_len      = {b, 8'h00};
        running_crc = crc_fold(running_crc, b);
        rx_phase    = PH_LENLO;
      end
      PH_LENLO: begin
        rx_len[7:0] = b;
        running_crc = crc_fold(running_crc, b);
        data_count  = 0;
        cap = (max_len > MAX_BLOCK) ? MAX_BLOCK : int'(max_len);
        // Oversized length: reject at once and go back to hunting
        if (int'(rx_len) > cap) begin
          rx_phase = PH_HUNT1;
          expect_result(KIND_NAK, nak_val, rx_seq);
        end else begin
          rx_phase = (rx_len == 16'd0) ? PH_CRCHI : PH_DATA;
        end
      end
      PH_DATA: begin
        running_crc = crc_fold(running_crc, b);
        data_count++;
        if (data_count >= int'(rx_len)) rx_phase = PH_CRCHI;
        expect_result(KIND_DATA, b, rx_seq);
      end
      PH_CRCHI: begin
        crc_hi   = b;
        rx_phase = PH_CRCLO;
      end
      PH_CRCLO: begin
        rx_phase = PH_HUNT1;
        // Verdict order: CRC, then end frame, then sequence
        if ({crc_hi, b} != running_crc) begin
          expect_result(KIND_NAK, nak_val, rx_seq);
        end else if (rx_seq == end_seq && rx_len == 16'd0) begin
          next_seq = 16'd0;
          expect_result(KIND_END, 8'h00, rx_seq);
        end else if (rx_seq != next_seq) begin
          expect_result(KIND_NAK, nak_val, rx_seq);
        end else begin
          next_seq = next_seq + 16'd1;
          expect_result(KIND_ACK, ack_val, rx_seq);
        end
      end
      default: rx_phase = PH_HUNT1;
    endcase
  endtask

  // Compare one result beat against the oldest expectation
  task automatic check_result_beat();
    frame_result_t want;
    if (frame_results_q.size() == 0) begin
      $error("result beat with nothing expected: kind %0d, byte %02h, frame %04h",
             out_kind, out_byte, out_frame_number);
      fail_count++;
    end else begin
      want = frame_results_q.pop_front();
      if (out_kind !== want.kind) begin
        $error("out_kind mismatch: expected %0d, actual %0d", want.kind, out_kind);
        fail_count++;
      end
      if (out_byte !== want.code) begin
        $error("out_byte mismatch: expected %02h, actual %02h", want.code, out_byte);
        fail_count++;
      end
      if (out_frame_number !== want.frame) begin
        $error("out_frame_number mismatch: expected %04h, actual %04h",
               want.frame, out_frame_number);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_a       = 8'hAA;
      hdr_b       = 8'h55;
      ack_val     = 8'h06;
      nak_val     = 8'h15;
      end_seq     = 16'hFFFF;
      max_len     = 13'd1024;
      rx_phase    = PH_HUNT1;
      next_seq    = 16'd0;
      rx_seq      = 16'd0;
      rx_len      = 16'd0;
      data_count  = 0;
      running_crc = CRC_INIT;
      crc_hi      = 8'h00;
      fail_count  = 0;
      frame_results_q.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_HEADER_FIRST:  hdr_a   = cfg_data[7:0];
          REG_HEADER_SECOND: hdr_b   = cfg_data[7:0];
          REG_ACK_CODE:      ack_val = cfg_data[7:0];
          REG_NAK_CODE:      nak_val = cfg_data[7:0];
          REG_END_SEQUENCE:  end_seq = cfg_data;
          REG_MAX_PAYLOAD:   max_len = cfg_data[12:0];
          default: ;
        endcase
      end
      // A result never comes from the byte accepted at the same edge
      if (out_valid && out_ready) check_result_beat();
      if (in_valid && in_ready) take_rx_byte(in_rx_byte);
    end
    pending = frame_results_q.size();
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives framed byte streams into the block frame receiver: directed frames
// for each verdict path, then phases of random frames, noise and broken
// frames under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bfr_pkg::*;

  localparam int LIMIT         = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_BEATS   = 190;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [15:0] out_frame_number;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'h0000;

  int          fail_count;
  int          pending;
  logic [15:0] exp_seq;

  // Register values as last written (reset values to start)
  logic [15:0] cfg_val [6] = '{16'h00AA, 16'h0055, 16'h0006, 16'h0015, 16'hFFFF, 16'd1024};
  logic [7:0]  payload_q[$];
  int          beats_sent = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;
  int          hold_asks = 0;
  int          hold_done = 0;
  int          stall_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  block_frame_receiver dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_frame_number (out_frame_number),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  bfr_frame_checker frame_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_frame_number (out_frame_number),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending),
    .next_seq         (exp_seq)
  );

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int k;
    c = crc ^ {8'h00, b};
    for (k = 0; k < 8; k++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic int payload_cap();
    int cap;
    cap = int'(cfg_val[REG_MAX_PAYLOAD][12:0]);
    return (cap > MAX_BLOCK) ? MAX_BLOCK : cap;
  endfunction

  // Mostly short payloads, sometimes at the limit or 64, whichever is smaller
  function automatic logic [15:0] pick_len();
    int cap, top_len;
    cap = payload_cap();
    if (cap == 0) return 16'd0;
    if ($urandom_range(0, 19) == 0) return 16'((cap > 64) ? 64 : cap);
    top_len = ($urandom_range(0, 7) == 0) ? 64 : 8;
    if (top_len > cap) top_len = cap;
    return 16'($urandom_range(0, top_len));
  endfunction

  // Offer one beat, with an optional gap first, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    @(negedge clk);
  endtask

  // Build a frame around payload_q and send it, whole or cut short
  task automatic send_frame(input logic [15:0] seq, input logic [15:0] len,
                            input bit bad_crc, input int cut);
    logic [7:0]  frame_q[$];
    logic [15:0] crc;
    int          i, n;
    frame_q.push_back(cfg_val[REG_HEADER_FIRST][7:0]);
    frame_q.push_back(cfg_val[REG_HEADER_SECOND][7:0]);
    frame_q.push_back(seq[15:8]);
    frame_q.push_back(seq[7:0]);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
    if (int'(len) <= payload_cap())
      foreach (payload_q[j]) frame_q.push_back(payload_q[j]);
    crc = CRC_INIT;
    for (i = 2; i < frame_q.size(); i++) crc = crc16_modbus(crc, frame_q[i]);
    if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    frame_q.push_back(crc[15:8]);
    frame_q.push_back(crc[7:0]);
    // An oversized length ends the frame right after the length field
    n = (int'(len) > payload_cap()) ? 6 : frame_q.size();
    if (cut > 0 && cut < n) n = cut;
    for (i = 0; i < n; i++) send_byte(frame_q[i]);
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all registers from cfg_val, one per cycle
  task automatic apply_settings();
    int i;
    for (i = REG_HEADER_FIRST; i <= REG_MAX_PAYLOAD; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= cfg_val[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic choose_settings(input int phase_no);
    int i;
    for (i = REG_HEADER_FIRST; i <= REG_MAX_PAYLOAD; i++)
      cfg_val[i] = (i == REG_END_SEQUENCE) ? 16'($urandom) : 16'($urandom_range(0, 255));
    cfg_val[REG_MAX_PAYLOAD] = 16'($urandom_range(1, 64));
    case (phase_no)
      0: begin
        // Low extremes; a zero limit lets only empty frames through
        cfg_val[REG_HEADER_FIRST]  = 16'h0000;
        cfg_val[REG_HEADER_SECOND] = 16'h00FF;
        cfg_val[REG_ACK_CODE]      = 16'h0000;
        cfg_val[REG_NAK_CODE]      = 16'h00FF;
        cfg_val[REG_END_SEQUENCE]  = 16'h0000;
        cfg_val[REG_MAX_PAYLOAD]   = 16'd0;
      end
      1: begin
        cfg_val[REG_HEADER_FIRST]  = 16'h00FF;
        cfg_val[REG_HEADER_SECOND] = 16'h0000;
        cfg_val[REG_ACK_CODE]      = 16'h00FF;
        cfg_val[REG_NAK_CODE]      = 16'h0000;
        cfg_val[REG_END_SEQUENCE]  = 16'hFFFF;
        cfg_val[REG_MAX_PAYLOAD]   = 16'(MAX_BLOCK);
      end
      2: cfg_val[REG_MAX_PAYLOAD] = 16'd1;
      4: cfg_val[REG_MAX_PAYLOAD] = 16'(MAX_BLOCK);
      default: ;
    endcase
  endtask

  // One random frame, broken frame or burst of noise
  task automatic random_frame();
    int          pick, n, i;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    len  = pick_len();
    payload_q.delete();
    for (i = 0; i < int'(len); i++) payload_q.push_back(8'($urandom_range(0, 255)));
    if (pick < 55) begin
      send_frame(exp_seq, len, 1'b0, 0);
    end else if (pick < 60) begin
      payload_q.delete();
      send_frame(cfg_val[REG_END_SEQUENCE], 16'd0, 1'b0, 0);
    end else if (pick < 68) begin
      send_frame(exp_seq ^ (16'd1 << $urandom_range(0, 15)), len, 1'b0, 0);
    end else if (pick < 76) begin
      send_frame(exp_seq, len, 1'b1, 0);
    end else if (pick < 83) begin
      len = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'(payload_cap() + $urandom_range(1, 4));
      send_frame(exp_seq, len, 1'b0, 0);
    end else if (pick < 90) begin
      send_frame(exp_seq, len, 1'b0, $urandom_range(1, 7 + int'(len)));
    end else begin
      // Noise, sometimes a first header byte followed by a wrong second one
      if ($urandom_range(0, 2) == 0) begin
        send_byte(cfg_val[REG_HEADER_FIRST][7:0]);
        send_byte(cfg_val[REG_HEADER_SECOND][7:0] ^ 8'($urandom_range(1, 255)));
      end
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Result side: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_done != hold_asks) begin
      hold_done  = hold_asks;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) stall_left = idle_len();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int phase_no, sent_mark;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Good frame with extreme payload bytes
    payload_q.push_back(8'h00);
    payload_q.push_back(8'hFF);
    send_frame(16'd0, 16'd2, 1'b0, 0);
    // Empty frame goes straight to the CRC
    payload_q.delete();
    send_frame(16'd1, 16'd0, 1'b0, 0);
    // CRC error
    payload_q.push_back(8'h5A);
    send_frame(16'd2, 16'd1, 1'b1, 0);
    // Sequence mismatch
    payload_q.delete();
    send_frame(16'd7, 16'd0, 1'b0, 0);
    // Lengths over the limit
    send_frame(16'd2, 16'd1025, 1'b0, 0);
    send_frame(16'd2, 16'hFFFF, 1'b0, 0);
    // Wrong second header byte; the repeated first byte must not restart
    send_byte(cfg_val[REG_HEADER_FIRST][7:0]);
    send_byte(cfg_val[REG_HEADER_FIRST][7:0]);
    send_byte(cfg_val[REG_HEADER_SECOND][7:0]);
    payload_q.push_back(8'h80);
    send_frame(16'd2, 16'd1, 1'b0, 0);
    // End sequence with a payload is not an end frame
    send_frame(16'hFFFF, 16'd1, 1'b0, 0);
    // End frame, then the sequence restarts from zero
    payload_q.delete();
    send_frame(16'hFFFF, 16'd0, 1'b0, 0);
    payload_q.push_back(8'h7F);
    send_frame(16'd0, 16'd1, 1'b0, 0);

    for (phase_no = 0; phase_no < 6; phase_no++) begin
      settle();
      choose_settings(phase_no);
      apply_settings();
      quiet = (phase_no == 3);
      if (phase_no == 1) hold_asks++;
      sent_mark = beats_sent;
      while (beats_sent - sent_mark < PHASE_BEATS) random_frame();
    end

    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bfr_pkg.sv
rtl/bfr_crc16.sv
rtl/block_frame_receiver.sv
rtl/bfr_checker.sv
tb/bfr_frame_checker.sv
tb/tb_top.sv
